// ===== rtl/dsb_pkg.sv =====
// dsb_pkg: widths, types, register indexes and reset values for the
// delay-and-sum beamformer core. No dependencies.
package dsb_pkg;

    localparam int NCH          = 4;
    localparam int DELAY_DEPTH  = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int BEAM_BITS    = SAMPLE_BITS + 2;
    localparam int DELAY_BITS   = 4;
    localparam int ADDR_W       = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CMP_W        = ((ADDR_W > DELAY_BITS) ? ADDR_W : DELAY_BITS) + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = DELAY_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [BEAM_BITS-1:0]   t_beam;
    typedef logic [ADDR_W-1:0]             t_addr;
    typedef logic [DELAY_BITS-1:0]         t_delay;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_CH1 = 3'd0,
        REG_DELAY_CH2 = 3'd1,
        REG_DELAY_CH3 = 3'd2,
        REG_DELAY_CH4 = 3'd3,
        REG_SUM_MODE  = 3'd4
    } t_reg_idx;

    localparam t_delay DELAY_CH1_RST = 4'd0;
    localparam t_delay DELAY_CH2_RST = 4'd1;
    localparam t_delay DELAY_CH3_RST = 4'd3;
    localparam t_delay DELAY_CH4_RST = 4'd4;

endpackage

// ===== rtl/delay_and_sum_beamformer_core.sv =====
// delay_and_sum_beamformer_core: four-microphone delay-and-sum beamformer
// with one circular delay memory per microphone. Depends on dsb_pkg.
//
// One frame (four signed samples) is taken per word on the input channel and
// one beam word comes out per frame. Each microphone runs through its own
// delay memory; the per-channel delay (0..15 frames, clamped to the memory
// depth minus one) picks which stored frame joins the sum, and a delay of zero
// uses the incoming sample itself. After reset the lines read as zero until
// written, tracked by a write pointer and a wrap flag, so no clearing pass is
// needed. The four aligned samples are added; in average mode the sum is
// shifted right arithmetically by two (rounds toward minus infinity), in sum
// mode the raw 18-bit sum is output. A new frame is accepted every cycle while
// the input is not stalled; a frame's beam word passes through the read stage
// (the synchronous memory read) and then the adder into the output register.
// Stall on the output backs up through the read stage, so up to two words sit
// inside the block before the input is stalled. Configuration writes take
// effect at once and are meant to be made while the block is idle.
module delay_and_sum_beamformer_core
    import dsb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // input frame channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_mic1_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_mic2_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_mic3_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_mic4_sample,

    // beam output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [BEAM_BITS-1:0] o_beam_sample
);

    // configuration registers
    t_delay r_delay [NCH];
    logic   r_sum_mode;

    // shared write pointer and wrap flag (fill tracking for the zero reset)
    t_addr  r_wr_pos;
    logic   r_full;

    // read stage: memory data plus what is needed to pick the sample
    logic    r_s1_valid;
    t_sample r_rd_data [NCH];
    t_sample r_s1_in   [NCH];
    logic    r_s1_zero [NCH];
    logic    r_s1_hit  [NCH];

    // output register
    logic    r_out_valid;
    t_beam   r_out_beam;

    t_sample in_sample [NCH];
    t_addr   rd_addr   [NCH];
    logic    rd_hit    [NCH];
    logic    d_zero    [NCH];
    logic    s1_adv;
    logic    in_acc;
    t_beam   beam_sum;
    t_beam   n_out_beam;

    assign in_sample[0] = i_mic1_sample;
    assign in_sample[1] = i_mic2_sample;
    assign in_sample[2] = i_mic3_sample;
    assign in_sample[3] = i_mic4_sample;

    // handshake: the read stage moves on when the output register is free
    // or being taken; the input stalls only when the read stage cannot move
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay[0] <= DELAY_CH1_RST;
            r_delay[1] <= DELAY_CH2_RST;
            r_delay[2] <= DELAY_CH3_RST;
            r_delay[3] <= DELAY_CH4_RST;
            r_sum_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DELAY_CH1: r_delay[0] <= i_cfg_data[DELAY_BITS-1:0];
                REG_DELAY_CH2: r_delay[1] <= i_cfg_data[DELAY_BITS-1:0];
                REG_DELAY_CH3: r_delay[2] <= i_cfg_data[DELAY_BITS-1:0];
                REG_DELAY_CH4: r_delay[3] <= i_cfg_data[DELAY_BITS-1:0];
                REG_SUM_MODE:  r_sum_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // read address per channel: write pointer minus clamped delay, modulo depth
    always_comb begin
        logic [CMP_W-1:0] d_ext;
        logic [CMP_W-1:0] pos_ext;
        logic [CMP_W-1:0] rd_ext;
        for (int c = 0; c < NCH; c++) begin
            d_ext   = CMP_W'(r_delay[c]);
            if (d_ext > CMP_W'(DELAY_DEPTH - 1)) begin
                d_ext = CMP_W'(DELAY_DEPTH - 1);
            end
            pos_ext = CMP_W'(r_wr_pos);
            if (pos_ext >= d_ext) begin
                rd_ext = pos_ext - d_ext;
            end else begin
                rd_ext = pos_ext + CMP_W'(DELAY_DEPTH) - d_ext;
            end
            rd_addr[c] = rd_ext[ADDR_W-1:0];
            d_zero[c]  = (d_ext == '0);
            // entries not yet written since reset read as zero
            rd_hit[c]  = r_full || (rd_addr[c] < r_wr_pos);
        end
    end

    // write pointer advances once per accepted frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_full   <= 1'b0;
        end else if (in_acc) begin
            if (r_wr_pos == t_addr'(DELAY_DEPTH - 1)) begin
                r_wr_pos <= '0;
                r_full   <= 1'b1;
            end else begin
                r_wr_pos <= r_wr_pos + t_addr'(1);
            end
        end
    end

    // one delay memory per microphone: write at the pointer, read at the
    // delayed address; the read never hits the entry written in the same
    // cycle since a nonzero delay is always below the depth
    for (genvar c = 0; c < NCH; c++) begin : g_line
        t_sample r_mem [DELAY_DEPTH];

        always_ff @(posedge i_clk) begin
            if (in_acc) begin
                r_mem[r_wr_pos] <= in_sample[c];
                r_rd_data[c]    <= r_mem[rd_addr[c]];
            end
        end

        // sample selection info, payload only
        always_ff @(posedge i_clk) begin
            if (in_acc) begin
                r_s1_in[c]   <= in_sample[c];
                r_s1_zero[c] <= d_zero[c];
                r_s1_hit[c]  <= rd_hit[c];
            end
        end
    end

    // read stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // pick each aligned sample and add the four
    always_comb begin
        t_sample pick;
        beam_sum = '0;
        for (int c = 0; c < NCH; c++) begin
            if (r_s1_zero[c]) begin
                pick = r_s1_in[c];
            end else if (r_s1_hit[c]) begin
                pick = r_rd_data[c];
            end else begin
                pick = '0;
            end
            beam_sum = beam_sum + t_beam'(pick);
        end
        if (r_sum_mode) begin
            n_out_beam = beam_sum;
        end else begin
            // average: divide by the channel count, rounding down
            n_out_beam = beam_sum >>> 2;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_beam <= n_out_beam;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_beam_sample = r_out_beam;

endmodule
